/* rtl/rfde_pkg.sv */
package rfde_pkg;

  // Built frame size and derived widths.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 64;
  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W     = 1 + YW + XW;
  localparam int AW_W       = $clog2(MAX_WIDTH + 1);
  localparam int AH_W       = $clog2(MAX_HEIGHT + 1);

  // Field widths.
  localparam int KIND_W  = 3;
  localparam int POS_W   = 16;
  localparam int PIX_W   = 16;
  localparam int CNT_W   = 14;
  localparam int C_W     = 18;

  // Slave-side tdata layout, lowest bit first.
  localparam int KIND_LSB  = 0;
  localparam int X_LSB     = KIND_LSB + KIND_W;
  localparam int Y_LSB     = X_LSB + POS_W;
  localparam int RW_LSB    = Y_LSB + POS_W;
  localparam int RH_LSB    = RW_LSB + POS_W;
  localparam int COLOR_LSB = RH_LSB + POS_W;
  localparam int IN_DATA_W = ((COLOR_LSB + PIX_W + 7) / 8) * 8;

  localparam int OUT_DATA_W = 1 + CNT_W + 1;

  // Configuration registers.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int FW_W       = 8;
  localparam int FH_W       = 7;
  localparam int ROT_W      = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd2;
  localparam logic [FW_W-1:0]      FW_RESET         = 8'd128;
  localparam logic [FH_W-1:0]      FH_RESET         = 7'd64;
  localparam logic [ROT_W-1:0]     ROT_RESET        = 2'd0;
  localparam logic [ROT_W-1:0]     ROT_MIRROR       = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILL_SCREEN = 3'd0,
    KIND_FILL_RECT   = 3'd1,
    KIND_PUT_PIXEL   = 3'd2,
    KIND_BLIT_START  = 3'd3,
    KIND_BLIT_PIXEL  = 3'd4,
    KIND_COMMIT      = 3'd5
  } kind_e;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic setup;
    logic run_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic long_kind;
    logic setup_empty;
    logic run_last;
  } sts_t;

endpackage

/* rtl/rotated_framebuffer_draw_engine_top.sv */
// Channel     | Direction | Signals                  | Contents (lowest bit first)
// ------------+-----------+--------------------------+-----------------------------------------
// command     | in        | s_tvalid/s_tready/s_tdata | kind, x_pos, y_pos, rect_width,
//             |           |                          | rect_height, color, zero pad to 88 bits
// result      | out       | m_tvalid/m_tready/m_tdata | status, pixels_written, front_index
// config      | in        | cfg_we/cfg_idx/cfg_data  | frame_width, frame_height, rotation
//
// Write pixel, blit start, blit pixel and unused kinds: one item per cycle unless held.
// Fills and commit write the pixels of their region one by one through the single
// memory write port; the commit copy and the screen fill cover the active frame.
// After reset a clearing pass writes zero to all 2 * 128 * 64 = 16384 pixels, one per
// cycle, before the first item is taken; configuration writes are taken during it.
// A result that waits unaccepted holds the next item off until it is taken.
module rotated_framebuffer_draw_engine_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rfde_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rfde_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // kind[2:0], x_pos[18:3], y_pos[34:19], rect_width[50:35], rect_height[66:51],
  // color[82:67], zero[87:83]
  input  logic [rfde_pkg::IN_DATA_W-1:0]   s_tdata_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // status[0], pixels_written[14:1], front_index[15]
  output logic [rfde_pkg::OUT_DATA_W-1:0]  m_tdata_o
);

  rfde_pkg::cmd_t cmd;
  rfde_pkg::sts_t sts;

  rfde_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rfde_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_tdata_i),
    .out_data_o (m_tdata_o)
  );

endmodule

/* rtl/rfde_controller.sv */
module rfde_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output rfde_pkg::cmd_t cmd_o,
  input  rfde_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_free;
  logic   accept;

  assign out_free   = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = m_valid_q;

  assign cmd_o.clear_step  = (state_q == ST_CLEAR);
  assign cmd_o.accept      = accept;
  assign cmd_o.setup       = (state_q == ST_SETUP);
  assign cmd_o.run_step    = (state_q == ST_RUN);
  assign cmd_o.load_result = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= (m_valid_q && !m_tready_i) || (accept && !sts_i.long_kind) ||
                   cmd_o.load_result;
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept && sts_i.long_kind) state_q <= ST_SETUP;
        end
        ST_SETUP: begin
          state_q <= sts_i.setup_empty ? ST_DONE : ST_RUN;
        end
        ST_RUN: begin
          if (sts_i.run_last) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rfde_datapath.sv */
module rfde_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rfde_pkg::cmd_t                     cmd_i,
  output rfde_pkg::sts_t                     sts_o,
  input  logic                               cfg_we_i,
  input  logic [rfde_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rfde_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [rfde_pkg::IN_DATA_W-1:0]     in_data_i,
  output logic [rfde_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int XW     = rfde_pkg::XW;
  localparam int YW     = rfde_pkg::YW;
  localparam int ADDR_W = rfde_pkg::ADDR_W;
  localparam int AW_W   = rfde_pkg::AW_W;
  localparam int AH_W   = rfde_pkg::AH_W;
  localparam int C_W    = rfde_pkg::C_W;
  localparam int POS_W  = rfde_pkg::POS_W;
  localparam int PIX_W  = rfde_pkg::PIX_W;
  localparam int CNT_W  = rfde_pkg::CNT_W;

  // Configuration.
  logic [rfde_pkg::FW_W-1:0]  fw_q;
  logic [rfde_pkg::FH_W-1:0]  fh_q;
  logic [rfde_pkg::ROT_W-1:0] rot_q;
  logic [AW_W-1:0]            aw;
  logic [AH_W-1:0]            ah;
  logic signed [C_W-1:0]      aw_s;
  logic signed [C_W-1:0]      ah_s;
  logic                       mirror;

  // Input item fields.
  rfde_pkg::kind_e            kind_in;
  logic signed [POS_W-1:0]    x_in;
  logic signed [POS_W-1:0]    y_in;
  logic signed [POS_W-1:0]    rw_in;
  logic signed [POS_W-1:0]    rh_in;
  logic [PIX_W-1:0]           color_in;
  logic                       long_kind;
  logic                       start_ok;

  // Latched operands of a multi-cycle item.
  rfde_pkg::kind_e            kind_q;
  logic signed [POS_W-1:0]    x_q;
  logic signed [POS_W-1:0]    y_q;
  logic signed [POS_W-1:0]    rw_q;
  logic signed [POS_W-1:0]    rh_q;
  logic [PIX_W-1:0]           color_q;

  // Blit state.
  logic signed [POS_W-1:0]    ax_q;
  logic signed [POS_W-1:0]    ay_q;
  logic [POS_W-1:0]           bw_q;
  logic [POS_W-1:0]           bh_q;
  logic [POS_W-1:0]           col_q;
  logic [POS_W-1:0]           row_q;
  logic                       open_q;
  logic [POS_W-1:0]           col_nx;
  logic [POS_W-1:0]           row_nx;

  logic                       front_q;

  // Single pixel path.
  logic signed [C_W-1:0]      px;
  logic signed [C_W-1:0]      py;
  logic                       in_bounds;
  logic [XW-1:0]              px_lo;
  logic [YW-1:0]              py_lo;
  logic [XW-1:0]              mx;
  logic [YW-1:0]              my;
  logic                       put_we;

  // Region setup.
  logic signed [C_W-1:0]      xq_s, yq_s, rwq_s, rhq_s;
  logic signed [C_W-1:0]      x0, x1, y0, y1;
  logic signed [C_W-1:0]      x0c, x1c, y0c, y1c;
  logic                       setup_empty;
  logic signed [C_W-1:0]      span_w_s;
  logic signed [C_W-1:0]      span_h_s;

  // Region walk.
  logic [XW-1:0]              lx0_q, lx1_q, cx_q;
  logic [YW-1:0]              ly1_q, cy_q;
  logic [AW_W-1:0]            span_w_q;
  logic [AH_W-1:0]            span_h_q;
  logic                       empty_q;
  logic                       run_last;
  logic                       copy_mode;

  // Pixel memory.
  logic [PIX_W-1:0]           mem_q [2**ADDR_W];
  logic [ADDR_W-1:0]          clr_cnt_q;
  logic                       wr_pend_q;
  logic [ADDR_W-1:0]          wa_q;
  logic [PIX_W-1:0]           rd_q;
  logic                       we;
  logic [ADDR_W-1:0]          waddr;
  logic [PIX_W-1:0]           wdata;
  logic [ADDR_W-1:0]          raddr;

  // Result.
  logic                       res_status_q;
  logic [CNT_W-1:0]           res_count_q;
  logic                       res_front_q;
  logic                       single_status;
  logic [CNT_W-1:0]           single_count;
  logic [AW_W+AH_W-1:0]       area;

  // ---------------------------------------------------------------------------
  // Configuration registers and active frame size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= rfde_pkg::FW_RESET;
      fh_q  <= rfde_pkg::FH_RESET;
      rot_q <= rfde_pkg::ROT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfde_pkg::CFG_FRAME_WIDTH:  fw_q  <= cfg_data_i[rfde_pkg::FW_W-1:0];
        rfde_pkg::CFG_FRAME_HEIGHT: fh_q  <= cfg_data_i[rfde_pkg::FH_W-1:0];
        rfde_pkg::CFG_ROTATION:     rot_q <= cfg_data_i[rfde_pkg::ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one, anything above the built maximum as the maximum.
  assign aw = (fw_q == '0) ? AW_W'(1) :
              ((32'(fw_q) > rfde_pkg::MAX_WIDTH) ? AW_W'(rfde_pkg::MAX_WIDTH) : AW_W'(fw_q));
  assign ah = (fh_q == '0) ? AH_W'(1) :
              ((32'(fh_q) > rfde_pkg::MAX_HEIGHT) ? AH_W'(rfde_pkg::MAX_HEIGHT) : AH_W'(fh_q));
  assign aw_s   = C_W'(aw);
  assign ah_s   = C_W'(ah);
  assign mirror = (rot_q == rfde_pkg::ROT_MIRROR);

  // ---------------------------------------------------------------------------
  // Input fields.
  assign kind_in  = rfde_pkg::kind_e'(in_data_i[rfde_pkg::KIND_LSB +: rfde_pkg::KIND_W]);
  assign x_in     = in_data_i[rfde_pkg::X_LSB +: POS_W];
  assign y_in     = in_data_i[rfde_pkg::Y_LSB +: POS_W];
  assign rw_in    = in_data_i[rfde_pkg::RW_LSB +: POS_W];
  assign rh_in    = in_data_i[rfde_pkg::RH_LSB +: POS_W];
  assign color_in = in_data_i[rfde_pkg::COLOR_LSB +: PIX_W];

  assign long_kind = kind_in inside {rfde_pkg::KIND_FILL_SCREEN, rfde_pkg::KIND_FILL_RECT,
                                     rfde_pkg::KIND_COMMIT};
  assign start_ok  = !rw_in[POS_W-1] && (rw_in != '0) && !rh_in[POS_W-1] && (rh_in != '0);

  // ---------------------------------------------------------------------------
  // Single pixel: a plain write or the next pixel of the open blit.
  always_comb begin
    if (kind_in == rfde_pkg::KIND_BLIT_PIXEL) begin
      px = C_W'(ax_q) + C_W'(col_q);
      py = C_W'(ay_q) + C_W'(row_q);
    end else begin
      px = C_W'(x_in);
      py = C_W'(y_in);
    end
  end

  assign in_bounds = !px[C_W-1] && !py[C_W-1] && (px < aw_s) && (py < ah_s);
  assign px_lo     = px[XW-1:0];
  assign py_lo     = py[YW-1:0];
  assign mx = mirror ? XW'(aw - AW_W'(1) - AW_W'(px_lo)) : px_lo;
  assign my = mirror ? YW'(ah - AH_W'(1) - AH_W'(py_lo)) : py_lo;

  assign put_we = cmd_i.accept && in_bounds &&
                  ((kind_in == rfde_pkg::KIND_PUT_PIXEL) ||
                   ((kind_in == rfde_pkg::KIND_BLIT_PIXEL) && open_q));

  always_comb begin
    single_status = 1'b1;
    single_count  = '0;
    case (kind_in)
      rfde_pkg::KIND_PUT_PIXEL: begin
        single_status = !in_bounds;
        single_count  = CNT_W'(in_bounds);
      end
      rfde_pkg::KIND_BLIT_START: begin
        single_status = !start_ok;
      end
      rfde_pkg::KIND_BLIT_PIXEL: begin
        if (open_q) begin
          single_status = !in_bounds;
          single_count  = CNT_W'(in_bounds);
        end
      end
      default: ;
    endcase
  end

  assign col_nx = col_q + POS_W'(1);
  assign row_nx = row_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q    <= '0;
      ay_q    <= '0;
      bw_q    <= '0;
      bh_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      open_q  <= 1'b0;
      front_q <= 1'b0;
    end else if (cmd_i.accept) begin
      case (kind_in)
        rfde_pkg::KIND_BLIT_START: begin
          ax_q   <= x_in;
          ay_q   <= y_in;
          bw_q   <= rw_in;
          bh_q   <= rh_in;
          col_q  <= '0;
          row_q  <= '0;
          open_q <= start_ok;
        end
        rfde_pkg::KIND_BLIT_PIXEL: begin
          // The spans are positive while a blit is open, so unsigned compares hold.
          if (open_q) begin
            if (col_nx >= bw_q) begin
              col_q <= '0;
              if (row_nx >= bh_q) begin
                row_q  <= '0;
                open_q <= 1'b0;
              end else begin
                row_q <= row_nx;
              end
            end else begin
              col_q <= col_nx;
            end
          end
        end
        rfde_pkg::KIND_COMMIT: begin
          front_q <= !front_q;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Region setup for fills and the commit copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_in;
      x_q     <= x_in;
      y_q     <= y_in;
      rw_q    <= rw_in;
      rh_q    <= rh_in;
      color_q <= color_in;
    end
  end

  assign xq_s  = C_W'(x_q);
  assign yq_s  = C_W'(y_q);
  assign rwq_s = C_W'(rw_q);
  assign rhq_s = C_W'(rh_q);

  always_comb begin
    if (mirror) begin
      x0 = aw_s - xq_s - rwq_s;
      x1 = aw_s - C_W'(1) - xq_s;
      y0 = ah_s - yq_s - rhq_s;
      y1 = ah_s - C_W'(1) - yq_s;
    end else begin
      x0 = xq_s;
      x1 = xq_s + rwq_s - C_W'(1);
      y0 = yq_s;
      y1 = yq_s + rhq_s - C_W'(1);
    end
    if (kind_q == rfde_pkg::KIND_FILL_RECT) begin
      x0c = x0[C_W-1] ? '0 : x0;
      y0c = y0[C_W-1] ? '0 : y0;
      x1c = (x1 >= aw_s) ? aw_s - C_W'(1) : x1;
      y1c = (y1 >= ah_s) ? ah_s - C_W'(1) : y1;
      setup_empty = rw_q[POS_W-1] || (rw_q == '0) || rh_q[POS_W-1] || (rh_q == '0) ||
                    (x0c > x1c) || (y0c > y1c);
    end else begin
      x0c = '0;
      y0c = '0;
      x1c = aw_s - C_W'(1);
      y1c = ah_s - C_W'(1);
      setup_empty = 1'b0;
    end
  end

  assign span_w_s = x1c - x0c + C_W'(1);
  assign span_h_s = y1c - y0c + C_W'(1);

  // ---------------------------------------------------------------------------
  // Region walk in row order, one pixel a cycle.
  assign run_last  = (cx_q == lx1_q) && (cy_q == ly1_q);
  assign copy_mode = (kind_q == rfde_pkg::KIND_COMMIT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      lx0_q    <= x0c[XW-1:0];
      lx1_q    <= x1c[XW-1:0];
      ly1_q    <= y1c[YW-1:0];
      cx_q     <= x0c[XW-1:0];
      cy_q     <= y0c[YW-1:0];
      span_w_q <= span_w_s[AW_W-1:0];
      span_h_q <= span_h_s[AH_W-1:0];
      empty_q  <= setup_empty;
    end else if (cmd_i.run_step) begin
      if (cx_q == lx1_q) begin
        cx_q <= lx0_q;
        cy_q <= cy_q + YW'(1);
      end else begin
        cx_q <= cx_q + XW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel memory: one write port, one registered read port for the commit copy.
  // The copy reads the new front plane and writes the back plane in the cycle after each read.
  always_comb begin
    we    = 1'b1;
    waddr = clr_cnt_q;
    wdata = '0;
    if (cmd_i.clear_step) begin
      waddr = clr_cnt_q;
    end else if (wr_pend_q) begin
      waddr = wa_q;
      wdata = rd_q;
    end else if (cmd_i.run_step && !copy_mode) begin
      waddr = {!front_q, cy_q, cx_q};
      wdata = color_q;
    end else if (put_we) begin
      waddr = {!front_q, my, mx};
      wdata = color_in;
    end else begin
      we = 1'b0;
    end
  end

  assign raddr = {front_q, cy_q, cx_q};

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.run_step && copy_mode) begin
      rd_q <= mem_q[raddr];
      wa_q <= {!front_q, cy_q, cx_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      wr_pend_q <= cmd_i.run_step && copy_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  assign area = (AW_W+AH_W)'(span_w_q) * (AW_W+AH_W)'(span_h_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !long_kind) begin
      res_status_q <= single_status;
      res_count_q  <= single_count;
      res_front_q  <= front_q;
    end else if (cmd_i.load_result) begin
      res_status_q <= empty_q;
      res_count_q  <= empty_q ? '0 : area[CNT_W-1:0];
      res_front_q  <= front_q;
    end
  end

  assign out_data_o = {res_front_q, res_count_q, res_status_q};

  assign sts_o.clear_last  = &clr_cnt_q;
  assign sts_o.long_kind   = long_kind;
  assign sts_o.setup_empty = setup_empty;
  assign sts_o.run_last    = run_last;

endmodule
